// ===== rtl/core/evmcba_pkg.sv =====
package evmcba_pkg;

    localparam int unsigned WORD_W = 256;
    localparam int unsigned LIMB_W = 64;
    localparam int unsigned LIMBS  = 4;

    // Operation codes, the opcode minus 0x10. Code 15 has no meaning.
    typedef enum logic [3:0] {
        OP_LT        = 4'd0,
        OP_GT        = 4'd1,
        OP_SLT       = 4'd2,
        OP_SGT       = 4'd3,
        OP_EQ        = 4'd4,
        OP_ZERO_TEST = 4'd5,
        OP_AND       = 4'd6,
        OP_OR        = 4'd7,
        OP_XOR       = 4'd8,
        OP_NOT       = 4'd9,
        OP_BYTE      = 4'd10,
        OP_SHL       = 4'd11,
        OP_SHR       = 4'd12,
        OP_SAR       = 4'd13,
        OP_CLZ       = 4'd14
    } op_t;

    // Revision levels of the instruction set.
    localparam logic [1:0] REV_BASE  = 2'd0;
    localparam logic [1:0] REV_SHIFT = 2'd1;
    localparam logic [1:0] REV_CLZ   = 2'd2;

    // Leading zero count of one limb; 64 when the limb is zero.
    function automatic logic [6:0] lzc64(input logic [LIMB_W-1:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < LIMB_W; i++) begin
            if (x[i]) begin
                n = 7'(LIMB_W - 1 - i);
            end
        end
        return n;
    endfunction

    // Bit reversal of a full word, so a left shift can use the right shifter.
    function automatic logic [WORD_W-1:0] rev256(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = x[WORD_W-1-i];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/evm_compare_bitwise_alu.sv =====
// 256-bit execute unit for the EVM comparison, bitwise, shift and CLZ opcodes.
// The slave stream (s_tvalid/s_tready) carries one operation per beat: the
// operation code in s_tuser and both 256-bit operands in s_tdata. The master
// stream (m_tvalid/m_tready) returns one beat per operation: the 256-bit result
// in m_tdata and a status flag in m_tuser that is set, with a zero result, for
// an opcode that the current revision does not enable or an undefined code.
// The cfg channel writes the revision level; cfg_ready is always high and a
// write should only be made while no operation is in flight.
// Each beat passes through three register stages: operand decode and limb
// compares, then compare combining, byte select and the coarse 64-bit shift,
// then the fine bit shift and the output register. Throughput is one beat per
// cycle. When the receiver stalls, each stage holds its beat; a stage that is
// empty still fills, so bubbles close up before s_tready drops. Reset empties
// the pipeline and sets the revision level to 2, which enables every op.
module evm_compare_bitwise_alu (
    input  logic         clk,
    input  logic         rst_n,
    // cfg_data: revision_level[1:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data,
    // s_tdata: top_w0, top_w1, top_w2, top_w3, second_w0, second_w1, second_w2,
    // second_w3 (64 bits each, from the lowest bit up)
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [511:0] s_tdata,
    // s_tuser: action[3:0]
    input  logic [3:0]   s_tuser,
    // m_tdata: result_w0, result_w1, result_w2, result_w3 (64 bits each)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata,
    // m_tuser: status[0]
    output logic [0:0]   m_tuser
);
    import evmcba_pkg::*;

    // Revision register.
    logic [1:0] rev_reg;

    // Pipeline valid bits and stage enables.
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    // Stage 1 payload.
    op_t               op1_reg;
    logic              bad1_reg;
    logic [WORD_W-1:0] a1_reg, b1_reg;
    logic [LIMBS-1:0]  lt1_reg, gt1_reg, eq1_reg, az1_reg;
    logic [6:0]        lzc1_reg [LIMBS];
    logic [8:0]        amt1_reg;
    logic              bok1_reg;

    // Stage 2 payload.
    logic              bad2_reg;
    logic              shift2_reg;
    logic              shl2_reg;
    logic              fill2_reg;
    logic [5:0]        fine2_reg;
    logic [WORD_W-1:0] res2_reg;
    logic [WORD_W-1:0] coarse2_reg;

    // Stage 3 (output) payload.
    logic [WORD_W-1:0] res3_reg;
    logic              st3_reg;

    // Stage 1 combinational.
    op_t               op_in;
    logic [WORD_W-1:0] a_in, b_in;
    logic              bad_in;
    logic [LIMBS-1:0]  lt_in, gt_in, eq_in, az_in;
    logic [8:0]        amt_in;

    // Stage 2 combinational.
    logic              ult_ab, ult_ba, slt_ab, sgt_ab, cmp_bit;
    logic [8:0]        clz_val;
    logic [4:0]        byte_pos;
    logic [7:0]        byte_val;
    logic              is_shift1, is_shl1, fill_in2;
    logic [WORD_W-1:0] shsrc, res2_next, coarse2_next;
    logic [2*WORD_W-1:0] wide2;

    // Stage 3 combinational.
    logic [WORD_W+LIMB_W-1:0] wide3;
    logic [WORD_W-1:0]        fine3, res3_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg <= REV_CLZ;
        end
        else if (cfg_valid)
        begin
            rev_reg <= cfg_data;
        end
    end

    // Handshake: a stage loads when it is empty or its beat moves on.
    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ---------------- Stage 1: decode, limb compares, CLZ per limb ----------
    assign op_in = op_t'(s_tuser);
    assign a_in  = s_tdata[WORD_W-1:0];
    assign b_in  = s_tdata[2*WORD_W-1:WORD_W];

    always_comb
    begin
        unique case (s_tuser) inside
            OP_SHL, OP_SHR, OP_SAR: bad_in = (rev_reg == REV_BASE);
            OP_CLZ:                 bad_in = (rev_reg < REV_CLZ);
            OP_LT, OP_GT, OP_SLT, OP_SGT, OP_EQ, OP_ZERO_TEST,
            OP_AND, OP_OR, OP_XOR, OP_NOT, OP_BYTE: bad_in = 1'b0;
            default:                bad_in = 1'b1;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            lt_in[i] = a_in[i*LIMB_W +: LIMB_W] < b_in[i*LIMB_W +: LIMB_W];
            gt_in[i] = a_in[i*LIMB_W +: LIMB_W] > b_in[i*LIMB_W +: LIMB_W];
            eq_in[i] = a_in[i*LIMB_W +: LIMB_W] == b_in[i*LIMB_W +: LIMB_W];
            az_in[i] = a_in[i*LIMB_W +: LIMB_W] == '0;
        end
    end

    // Shift amounts of 256 and above clamp to 256.
    assign amt_in = (a_in[WORD_W-1:8] != '0) ? 9'd256 : {1'b0, a_in[7:0]};

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg  <= op_in;
            bad1_reg <= bad_in;
            a1_reg   <= a_in;
            b1_reg   <= b_in;
            lt1_reg  <= lt_in;
            gt1_reg  <= gt_in;
            eq1_reg  <= eq_in;
            az1_reg  <= az_in;
            amt1_reg <= amt_in;
            bok1_reg <= (a_in[WORD_W-1:5] == '0);
            for (int i = 0; i < LIMBS; i++)
            begin
                lzc1_reg[i] <= lzc64(a_in[i*LIMB_W +: LIMB_W]);
            end
        end
    end

    // ---------------- Stage 2: combine compares, byte, coarse shift ---------
    assign ult_ab = lt1_reg[3] | (eq1_reg[3] & (lt1_reg[2] | (eq1_reg[2] &
                    (lt1_reg[1] | (eq1_reg[1] & lt1_reg[0])))));
    assign ult_ba = gt1_reg[3] | (eq1_reg[3] & (gt1_reg[2] | (eq1_reg[2] &
                    (gt1_reg[1] | (eq1_reg[1] & gt1_reg[0])))));
    assign slt_ab = (a1_reg[WORD_W-1] != b1_reg[WORD_W-1]) ? a1_reg[WORD_W-1] : ult_ab;
    assign sgt_ab = (a1_reg[WORD_W-1] != b1_reg[WORD_W-1]) ? b1_reg[WORD_W-1] : ult_ba;

    always_comb
    begin
        if (!az1_reg[3])
        begin
            clz_val = {2'b00, lzc1_reg[3]};
        end
        else if (!az1_reg[2])
        begin
            clz_val = 9'd64 + {2'b00, lzc1_reg[2]};
        end
        else if (!az1_reg[1])
        begin
            clz_val = 9'd128 + {2'b00, lzc1_reg[1]};
        end
        else
        begin
            clz_val = 9'd192 + {2'b00, lzc1_reg[0]};
        end
    end

    // Byte 0 is the most significant byte.
    assign byte_pos = ~a1_reg[4:0];
    assign byte_val = b1_reg[{byte_pos, 3'b000} +: 8];

    always_comb
    begin
        case (op1_reg)
            OP_LT:   cmp_bit = ult_ab;
            OP_GT:   cmp_bit = ult_ba;
            OP_SLT:  cmp_bit = slt_ab;
            OP_SGT:  cmp_bit = sgt_ab;
            OP_EQ:   cmp_bit = &eq1_reg;
            default: cmp_bit = &az1_reg;
        endcase
    end

    always_comb
    begin
        case (op1_reg) inside
            OP_LT, OP_GT, OP_SLT, OP_SGT, OP_EQ, OP_ZERO_TEST:
                res2_next = {{(WORD_W-1){1'b0}}, cmp_bit};
            OP_AND:  res2_next = a1_reg & b1_reg;
            OP_OR:   res2_next = a1_reg | b1_reg;
            OP_XOR:  res2_next = a1_reg ^ b1_reg;
            OP_NOT:  res2_next = ~a1_reg;
            OP_BYTE: res2_next = bok1_reg ? {{(WORD_W-8){1'b0}}, byte_val} : '0;
            OP_CLZ:  res2_next = {{(WORD_W-9){1'b0}}, clz_val};
            default: res2_next = '0;
        endcase
    end

    // Left shifts run through the right shifter on the bit-reversed value.
    assign is_shl1   = (op1_reg == OP_SHL);
    assign is_shift1 = (op1_reg == OP_SHL) || (op1_reg == OP_SHR) || (op1_reg == OP_SAR);
    assign fill_in2  = (op1_reg == OP_SAR) && b1_reg[WORD_W-1];
    assign shsrc     = is_shl1 ? rev256(b1_reg) : b1_reg;
    assign wide2     = {{WORD_W{fill_in2}}, shsrc};
    assign coarse2_next = amt1_reg[8] ? {WORD_W{fill_in2}}
                                      : wide2[{1'b0, amt1_reg[7:6], 6'd0} +: WORD_W];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            bad2_reg    <= bad1_reg;
            shift2_reg  <= is_shift1;
            shl2_reg    <= is_shl1;
            fill2_reg   <= fill_in2;
            fine2_reg   <= amt1_reg[8] ? 6'd0 : amt1_reg[5:0];
            res2_reg    <= res2_next;
            coarse2_reg <= coarse2_next;
        end
    end

    // ---------------- Stage 3: fine shift and output register ---------------
    assign wide3 = {{LIMB_W{fill2_reg}}, coarse2_reg};
    assign fine3 = wide3[{3'b000, fine2_reg} +: WORD_W];

    always_comb
    begin
        if (bad2_reg)
        begin
            res3_next = '0;
        end
        else if (shift2_reg)
        begin
            res3_next = shl2_reg ? rev256(fine3) : fine3;
        end
        else
        begin
            res3_next = res2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            res3_reg <= res3_next;
            st3_reg  <= bad2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = res3_reg;
    assign m_tuser  = st3_reg;

endmodule
